### src/request_frame_checker_macros.svh
// Assertion macros for the request frame checker.
// Used by the top level only; depends on nothing else.
`ifndef REQUEST_FRAME_CHECKER_MACROS_SVH
`define REQUEST_FRAME_CHECKER_MACROS_SVH
// Checks an implication on every clock edge outside reset.
`define RFC_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Checks that the property holds in the cycle after the condition.
`define RFC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

### src/rfc_pkg.sv
// Package for the request frame checker: status codes, header layout
// offsets and the CRC-32C byte update. Depends on nothing.
package rfc_pkg;
	localparam int unsigned HeaderBytes = 80;
	localparam int unsigned HeaderCrcOffset = 76;
	localparam int unsigned ReservedOffset = 52;
	localparam int unsigned ReservedBytes = 24;
	localparam int unsigned TrailerBytes = 4;
	localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
	localparam logic [63:0] Magic = 64'h3151_4552_5144_4843;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_LENGTH = 3'd1,
		ST_MAGIC = 3'd2,
		ST_HDR_CRC = 3'd3,
		ST_VERSION = 3'd4,
		ST_HDR_INVALID = 3'd5,
		ST_FRAME_CRC = 3'd6,
		ST_PAYLOAD_CRC = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CFG_MIN_PAYLOAD = 2'd0,
		CFG_MAX_PAYLOAD = 2'd1,
		CFG_MAX_FRAME = 2'd2
	} cfg_index_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction
endpackage

### src/rfc_verdict.sv
// Verdict logic of the request frame checker: ranks the checks in order.
// Depends on rfc_pkg.
module rfc_verdict import rfc_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic [LENGTH_BITS-1:0] frame_len,
	input  logic                   len_saturated,
	input  logic [31:0]            min_payload_length,
	input  logic [31:0]            max_payload_length,
	input  logic [31:0]            max_frame_length,
	input  logic                   magic_ok,
	input  logic                   reserved_zero,
	input  logic [31:0]            hcrc_run,
	input  logic [31:0]            hcrc_field,
	input  logic [31:0]            version_word,
	input  logic [31:0]            header_length_field,
	input  logic [63:0]            total_length_field,
	input  logic [63:0]            source_field,
	input  logic [63:0]            target_field,
	input  logic [63:0]            payload_length_field,
	input  logic [31:0]            frame_crc,
	input  logic [31:0]            tail_window,
	input  logic [31:0]            pcrc_run,
	input  logic [31:0]            payload_crc_field,
	output status_t                status
);
	localparam int unsigned WideBits = (LENGTH_BITS > 34) ? LENGTH_BITS + 1 : 35;
	logic [WideBits-1:0] n_w, min_frame_w, expect_pl_w;
	logic len_bad, hdr_bad, pl_neg;

	always_comb begin
		n_w = WideBits'(frame_len);
		min_frame_w = WideBits'(HeaderBytes + TrailerBytes) + WideBits'(min_payload_length);
		len_bad = len_saturated || (n_w < min_frame_w) || (n_w > WideBits'(max_frame_length));
		expect_pl_w = n_w - WideBits'(HeaderBytes + TrailerBytes);
		// The difference wraps for a frame shorter than the fixed overhead; such
		// a frame fails the length check first anyway.
		pl_neg = n_w < WideBits'(HeaderBytes + TrailerBytes);
		hdr_bad = (header_length_field != 32'(HeaderBytes)) ||
			(total_length_field != 64'(frame_len)) ||
			(source_field == 64'd0) || (target_field == 64'd0) ||
			(source_field == target_field) || !reserved_zero ||
			(payload_length_field < 64'(min_payload_length)) ||
			(payload_length_field > 64'(max_payload_length)) ||
			pl_neg || (payload_length_field != 64'(expect_pl_w));
		if (len_bad) status = ST_LENGTH;
		else if (!magic_ok) status = ST_MAGIC;
		else if (~hcrc_run != hcrc_field) status = ST_HDR_CRC;
		else if (version_word != 32'd1) status = ST_VERSION;
		else if (hdr_bad) status = ST_HDR_INVALID;
		else if (~frame_crc != tail_window) status = ST_FRAME_CRC;
		else if (~pcrc_run != payload_crc_field) status = ST_PAYLOAD_CRC;
		else status = ST_OK;
	end
endmodule

### src/request_frame_checker.sv
// Request frame checker: one frame byte per transfer in, payload bytes and
// one verdict per frame out. Depends on rfc_pkg, rfc_verdict and the macros header.
//
// Takes one byte per clock while the skid entry is empty, through an output
// register with a skid stage. Bytes update three CRC-32C accumulators, each
// over its own span, and fill the header fields; the final byte's verdict is
// ranked in the same cycle as its transfer and registered in the output
// register, or in the skid entry while the output register is stalled. Input
// stalls only while the output register and the skid entry are both full.
// Payload bytes inside the declared payload length are forwarded (kind 0);
// the last byte of a frame gives only the verdict (kind 1), which carries
// the status and the source and target node ids.
`include "request_frame_checker_macros.svh"
module request_frame_checker import rfc_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
	                                // [74:11] source_node, [138:75] target_node
	output logic         m_tuser,   // kind
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};

	logic [31:0] min_pl_q, max_pl_q, max_frame_q;
	logic [LENGTH_BITS-1:0] count_q, count_n;
	logic magic_ok_q, reserved_zero_q;
	logic [31:0] hcrc_q, pcrc_q, fcrc_q, tail_q, version_q, hlen_q, pcrc_field_q, stored_hcrc_q;
	logic [63:0] total_q, source_q, target_q, pl_len_q;

	logic [31:0] hcrc_n, pcrc_n, fcrc_n, tail_n, version_n, hlen_n, pcrc_field_n, stored_hcrc_n;
	logic [63:0] total_n, source_n, target_n, pl_len_n;
	logic magic_ok_n, reserved_zero_n, fwd;
	logic [7:0] b;
	logic accept;
	status_t status;

	// Output register plus skid entry.
	logic        out_v_q, skid_v_q;
	logic [138:0] out_d_q, skid_d_q;
	logic        out_k_q, skid_k_q;
	logic        res_v;
	logic [138:0] res_d;

	assign b = s_tdata;
	assign s_tready = !skid_v_q;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	function automatic logic [63:0] grab(input logic [63:0] f, input logic [LENGTH_BITS-1:0] i,
		input int unsigned off, input int unsigned size, input logic [7:0] d);
		logic [63:0] r;
		r = f;
		for (int k = 0; k < 8; k++) begin
			if (k < int'(size) && 64'(i) == 64'(off + k)) r[k*8 +: 8] = d;
		end
		return r;
	endfunction

	always_comb begin
		magic_ok_n = magic_ok_q;
		if (64'(count_q) < 64'd8 && b != Magic[count_q[2:0]*8 +: 8]) magic_ok_n = 1'b0;
		hcrc_n = (64'(count_q) < 64'(HeaderCrcOffset)) ? crc32c_byte(hcrc_q, b) : hcrc_q;
		version_n = 32'(grab(64'(version_q), count_q, 8, 4, b));
		hlen_n = 32'(grab(64'(hlen_q), count_q, 12, 4, b));
		total_n = grab(total_q, count_q, 16, 8, b);
		source_n = grab(source_q, count_q, 24, 8, b);
		target_n = grab(target_q, count_q, 32, 8, b);
		pl_len_n = grab(pl_len_q, count_q, 40, 8, b);
		pcrc_field_n = 32'(grab(64'(pcrc_field_q), count_q, 48, 4, b));
		stored_hcrc_n = 32'(grab(64'(stored_hcrc_q), count_q, HeaderCrcOffset, 4, b));
		reserved_zero_n = reserved_zero_q;
		if (64'(count_q) >= 64'(ReservedOffset) &&
			64'(count_q) < 64'(ReservedOffset + ReservedBytes) && b != 8'd0)
			reserved_zero_n = 1'b0;
		// Payload window uses the length captured before this byte.
		fwd = (64'(count_q) >= 64'(HeaderBytes)) &&
			((64'(count_q) - 64'(HeaderBytes)) < pl_len_q);
		pcrc_n = fwd ? crc32c_byte(pcrc_q, b) : pcrc_q;
		fcrc_n = (64'(count_q) >= 64'(TrailerBytes)) ? crc32c_byte(fcrc_q, tail_q[7:0]) : fcrc_q;
		tail_n = {b, tail_q[31:8]};
		count_n = (count_q == CountMax) ? CountMax : count_q + 1'b1;
	end

	rfc_verdict #(.LENGTH_BITS(LENGTH_BITS)) u_verdict (
		.frame_len(count_n), .len_saturated(count_n == CountMax),
		.min_payload_length(min_pl_q), .max_payload_length(max_pl_q),
		.max_frame_length(max_frame_q), .magic_ok(magic_ok_n),
		.reserved_zero(reserved_zero_n), .hcrc_run(hcrc_n),
		.hcrc_field(stored_hcrc_n), .version_word(version_n),
		.header_length_field(hlen_n), .total_length_field(total_n),
		.source_field(source_n), .target_field(target_n),
		.payload_length_field(pl_len_n), .frame_crc(fcrc_n), .tail_window(tail_n),
		.pcrc_run(pcrc_n), .payload_crc_field(pcrc_field_n), .status(status)
	);

	assign res_v = accept && (s_tlast || fwd);
	assign res_d = s_tlast ? {target_n, source_n, status, 8'd0} : {128'd0, 3'd0, b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pl_q <= '0;
			max_pl_q <= '1;
			max_frame_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_PAYLOAD: min_pl_q <= cfg_data;
				CFG_MAX_PAYLOAD: max_pl_q <= cfg_data;
				CFG_MAX_FRAME: max_frame_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			magic_ok_q <= 1'b1;
			reserved_zero_q <= 1'b1;
			hcrc_q <= '1;
			pcrc_q <= '1;
			fcrc_q <= '1;
			tail_q <= '0;
			version_q <= '0;
			hlen_q <= '0;
			total_q <= '0;
			source_q <= '0;
			target_q <= '0;
			pl_len_q <= '0;
			pcrc_field_q <= '0;
			stored_hcrc_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				count_q <= '0;
				magic_ok_q <= 1'b1;
				reserved_zero_q <= 1'b1;
				hcrc_q <= '1;
				pcrc_q <= '1;
				fcrc_q <= '1;
				tail_q <= '0;
				version_q <= '0;
				hlen_q <= '0;
				total_q <= '0;
				source_q <= '0;
				target_q <= '0;
				pl_len_q <= '0;
				pcrc_field_q <= '0;
				stored_hcrc_q <= '0;
			end else begin
				count_q <= count_n;
				magic_ok_q <= magic_ok_n;
				reserved_zero_q <= reserved_zero_n;
				hcrc_q <= hcrc_n;
				pcrc_q <= pcrc_n;
				fcrc_q <= fcrc_n;
				tail_q <= tail_n;
				version_q <= version_n;
				hlen_q <= hlen_n;
				total_q <= total_n;
				source_q <= source_n;
				target_q <= target_n;
				pl_len_q <= pl_len_n;
				pcrc_field_q <= pcrc_field_n;
				stored_hcrc_q <= stored_hcrc_n;
			end
		end
	end

	// A new result goes to the output register when it is free or draining,
	// otherwise into the skid entry, which stops input until it empties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_tready) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1;
					skid_v_q <= res_v;
				end else begin
					out_v_q <= res_v;
				end
			end else if (res_v) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
				out_k_q <= skid_k_q;
				if (res_v) begin
					skid_d_q <= res_d;
					skid_k_q <= s_tlast;
				end
			end else if (res_v) begin
				out_d_q <= res_d;
				out_k_q <= s_tlast;
			end
		end else if (res_v) begin
			skid_d_q <= res_d;
			skid_k_q <= s_tlast;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser = out_k_q;
	assign m_tdata = {5'd0, out_d_q};

	`RFC_ASSERT_IMP(a_no_accept_when_skid_full, clk, arst_n, skid_v_q, !s_tready,
		"input accepted while skid entry full")
	`RFC_ASSERT_NEXT(a_count_clears_after_last, clk, arst_n, accept && s_tlast, count_q == '0,
		"byte count not cleared after frame end")
	`RFC_ASSERT_IMP(a_skid_implies_out, clk, arst_n, skid_v_q, out_v_q,
		"skid entry holds data while output register is empty")
endmodule

### bench/tb_top.sv
// Self-checking testbench for request_frame_checker: builds request frames,
// predicts payload transfers and verdicts, and checks the output stream.
// Depends on rfc_pkg and the request_frame_checker RTL.
`timescale 1ns / 100ps
module tb_top import rfc_pkg::*; ();

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [63:0] source_node;
		logic [63:0] target_node;
	} out_item_t;

	typedef enum int {
		FX_NONE, FX_MAGIC, FX_HCRC, FX_VERSION, FX_HDRLEN, FX_TOTAL, FX_SRC0, FX_SAME,
		FX_RSVD, FX_PLEN_BIG, FX_PCRC, FX_TCRC, FX_SHORT, FX_NOISE
	} flaw_t;

	localparam logic [63:0] CountMax = 64'hFFFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_bus;
	logic         m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = CFG_MIN_PAYLOAD;
	logic [31:0]  cfg_data = '0;

	request_frame_checker DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_bus), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	in_item_t  pending_bytes[$];
	out_item_t expected_out[$];
	int        errors = 0;
	int        send_idle = 0;
	int        recv_stall = 0;
	int        hold_trig = 0;
	int        hold_seen = 0;
	int        hold_left = 0;

	// Configuration and frame state of the predictor.
	logic [31:0] min_plen, max_plen, max_flen;
	logic [63:0] cnt, total_f, src_f, tgt_f, plen_f;
	logic        magic_good, rsvd_clear;
	logic [31:0] hdr_crc, pay_crc, trl_crc, tail, ver_f, hlen_f, pcrc_f, hcrc_f;

	function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
		crc ^= {24'd0, b};
		for (int k = 0; k < 8; k++)
			crc = crc[0] ? ((crc >> 1) ^ 32'h82F6_3B78) : (crc >> 1);
		return crc;
	endfunction

	function automatic void clear_frame_state();
		cnt = '0; magic_good = 1'b1; rsvd_clear = 1'b1;
		hdr_crc = '1; pay_crc = '1; trl_crc = '1; tail = '0;
		ver_f = '0; hlen_f = '0; total_f = '0; src_f = '0; tgt_f = '0;
		plen_f = '0; pcrc_f = '0; hcrc_f = '0;
	endfunction

	// Advances the frame state by one accepted byte and queues what it yields.
	function automatic void predict_frame_byte(logic [7:0] b, logic lst);
		logic [63:0] i, n, min_frame;
		logic        fwd, len_bad, hdr_bad;
		out_item_t   r;
		status_t     st;
		i = cnt;
		if (i < 8 && b != Magic[8*i +: 8]) magic_good = 1'b0;
		if (i < 76) hdr_crc = crc_step(hdr_crc, b);
		if (i >= 8 && i < 12) ver_f[8*(i-8) +: 8] = b;
		if (i >= 12 && i < 16) hlen_f[8*(i-12) +: 8] = b;
		if (i >= 16 && i < 24) total_f[8*(i-16) +: 8] = b;
		if (i >= 24 && i < 32) src_f[8*(i-24) +: 8] = b;
		if (i >= 32 && i < 40) tgt_f[8*(i-32) +: 8] = b;
		if (i >= 40 && i < 48) plen_f[8*(i-40) +: 8] = b;
		if (i >= 48 && i < 52) pcrc_f[8*(i-48) +: 8] = b;
		if (i >= 52 && i < 76 && b != 0) rsvd_clear = 1'b0;
		if (i >= 76 && i < 80) hcrc_f[8*(i-76) +: 8] = b;
		fwd = (i >= 80) && (i - 80 < plen_f);
		if (fwd) pay_crc = crc_step(pay_crc, b);
		// The trailer CRC runs four bytes behind the input.
		if (i >= 4) trl_crc = crc_step(trl_crc, tail[7:0]);
		tail = {b, tail[31:8]};
		n = (i >= CountMax) ? CountMax : i + 1;
		cnt = n;
		r = '0;
		if (!lst) begin
			if (fwd) begin
				r.payload_byte = b;
				expected_out.push_back(r);
			end
			return;
		end
		min_frame = 64'd84 + min_plen;
		len_bad = n >= CountMax || n < min_frame || n > {32'd0, max_flen};
		hdr_bad = hlen_f != 32'd80 || total_f != n || src_f == 0 || tgt_f == 0 ||
			src_f == tgt_f || !rsvd_clear || plen_f < {32'd0, min_plen} ||
			plen_f > {32'd0, max_plen} || plen_f != n - 64'd84;
		if (len_bad) st = ST_LENGTH;
		else if (!magic_good) st = ST_MAGIC;
		else if (~hdr_crc != hcrc_f) st = ST_HDR_CRC;
		else if (ver_f != 32'd1) st = ST_VERSION;
		else if (hdr_bad) st = ST_HDR_INVALID;
		else if (~trl_crc != tail) st = ST_FRAME_CRC;
		else if (~pay_crc != pcrc_f) st = ST_PAYLOAD_CRC;
		else st = ST_OK;
		r.kind = 1'b1;
		r.status = st;
		r.source_node = src_f;
		r.target_node = tgt_f;
		expected_out.push_back(r);
		clear_frame_state();
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Builds one frame of payload length plen with the given flaw (for FX_NOISE a run of random bytes) and queues it.
	task automatic queue_frame(int plen, flaw_t flaw);
		logic [7:0]  fb[$];
		logic [31:0] c, ver, hlen;
		logic [63:0] total, src, tgt, plen_w;
		int          k, cut;
		if (flaw == FX_NOISE) begin
			cut = $urandom_range(1, 120);
			for (k = 0; k < cut; k++) fb.push_back($urandom_range(0, 255));
		end else begin
			ver = (flaw == FX_VERSION) ? ($urandom_range(0, 1) ? 32'h0001_0001 : 32'd2) : 32'd1;
			hlen = (flaw == FX_HDRLEN) ? 32'd79 + 2 * $urandom_range(0, 1) : 32'd80;
			total = 64'd84 + plen;
			if (flaw == FX_TOTAL) total ^= 64'd1 << $urandom_range(0, 63);
			src = {$urandom, $urandom};
			tgt = {$urandom, $urandom};
			if (src == 0) src = 64'd1;
			if (tgt == 0 || tgt == src) tgt = ~src;
			if (flaw == FX_SRC0) begin
				if ($urandom_range(0, 1)) src = '0; else tgt = '0;
			end
			if (flaw == FX_SAME) tgt = src;
			plen_w = plen;
			if (flaw == FX_PLEN_BIG) plen_w = plen + $urandom_range(1, 6);
			c = '1;
			for (k = 0; k < plen; k++) c = crc_step(c, 8'(k * 37 + plen));
			c = ~c;
			if (flaw == FX_PCRC) c ^= 32'd1 << $urandom_range(0, 31);
			for (k = 0; k < 8; k++) fb.push_back(Magic[8*k +: 8]);
			if (flaw == FX_MAGIC) fb[$urandom_range(0, 7)] ^= 8'd1 << $urandom_range(0, 7);
			for (k = 0; k < 4; k++) fb.push_back(ver[8*k +: 8]);
			for (k = 0; k < 4; k++) fb.push_back(hlen[8*k +: 8]);
			for (k = 0; k < 8; k++) fb.push_back(total[8*k +: 8]);
			for (k = 0; k < 8; k++) fb.push_back(src[8*k +: 8]);
			for (k = 0; k < 8; k++) fb.push_back(tgt[8*k +: 8]);
			for (k = 0; k < 8; k++) fb.push_back(plen_w[8*k +: 8]);
			for (k = 0; k < 4; k++) fb.push_back(c[8*k +: 8]);
			for (k = 0; k < 24; k++) fb.push_back(8'd0);
			if (flaw == FX_RSVD) fb[52 + $urandom_range(0, 23)] = $urandom_range(1, 255);
			c = '1;
			for (k = 0; k < 76; k++) c = crc_step(c, fb[k]);
			c = ~c;
			if (flaw == FX_HCRC) c ^= 32'd1 << $urandom_range(0, 31);
			for (k = 0; k < 4; k++) fb.push_back(c[8*k +: 8]);
			for (k = 0; k < plen; k++) fb.push_back(8'(k * 37 + plen));
			// Spread payload content over all bit values on most frames.
			if (flaw == FX_NONE || $urandom_range(0, 1))
				for (k = 80; k < fb.size(); k++) fb[k] = $urandom_range(0, 255);
			if (plen > 0 && fb.size() > 80) begin
				c = '1;
				for (k = 80; k < fb.size(); k++) c = crc_step(c, fb[k]);
				c = ~c;
				if (flaw == FX_PCRC) c ^= 32'h8000_0000;
				for (k = 0; k < 4; k++) fb[48 + k] = c[8*k +: 8];
				c = '1;
				for (k = 0; k < 76; k++) c = crc_step(c, fb[k]);
				c = ~c;
				if (flaw == FX_HCRC) c ^= 32'd1;
				for (k = 0; k < 4; k++) fb[76 + k] = c[8*k +: 8];
			end
			c = '1;
			for (k = 0; k < fb.size(); k++) c = crc_step(c, fb[k]);
			c = ~c;
			if (flaw == FX_TCRC) c ^= 32'd1 << $urandom_range(0, 31);
			for (k = 0; k < 4; k++) fb.push_back(c[8*k +: 8]);
			if (flaw == FX_SHORT) begin
				cut = $urandom_range(1, fb.size() - 1);
				while (fb.size() > cut) void'(fb.pop_back());
			end
		end
		for (k = 0; k < fb.size(); k++)
			pending_bytes.push_back('{fb[k], k == fb.size() - 1});
	endtask

	task automatic random_frames(int byte_goal, int plen_hi);
		int    start;
		flaw_t f;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < byte_goal) begin
			if ($urandom_range(0, 99) < 60) f = FX_NONE;
			else f = flaw_t'($urandom_range(FX_MAGIC, FX_NOISE));
			queue_frame($urandom_range(0, 19) == 0 ? $urandom_range(0, 200)
				: $urandom_range(0, plen_hi), f);
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || s_tvalid || expected_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MIN_PAYLOAD: min_plen = value;
			CFG_MAX_PAYLOAD: max_plen = value;
			default: max_flen = value;
		endcase
	endtask

	// Byte sender.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				s_tvalid <= 1'b1;
				{s_tdata, s_tlast} <= pending_bytes.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= hold_left == 0 && hold_trig == hold_seen &&
				$urandom_range(0, 99) >= recv_stall;
	end

	// Prediction on each input transfer, then comparison of each output transfer.
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && s_tvalid && s_tready) predict_frame_byte(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				report_mismatch("unexpected transfer", 64'({m_tuser, m_bus[10:0]}), 64'd0);
			end else begin
				w = expected_out.pop_front();
				if (m_tuser != w.kind) report_mismatch("kind", 64'(m_tuser), 64'(w.kind));
				if (m_bus[7:0] != w.payload_byte)
					report_mismatch("payload_byte", 64'(m_bus[7:0]), 64'(w.payload_byte));
				if (m_bus[10:8] != w.status)
					report_mismatch("status", 64'(m_bus[10:8]), 64'(w.status));
				if (m_bus[74:11] != w.source_node)
					report_mismatch("source_node", m_bus[74:11], w.source_node);
				if (m_bus[138:75] != w.target_node)
					report_mismatch("target_node", m_bus[138:75], w.target_node);
			end
		end
	end

	initial begin
		min_plen = '0;
		max_plen = '1;
		max_flen = '1;
		clear_frame_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed frames under reset settings: a good frame, a one-byte frame
		// and a cut-off frame.
		queue_frame(2, FX_NONE);
		pending_bytes.push_back('{8'hFF, 1'b1});
		queue_frame(4, FX_SHORT);
		wait_drained();

		write_reg(CFG_MIN_PAYLOAD, 32'd2);
		write_reg(CFG_MAX_PAYLOAD, 32'd10);
		write_reg(CFG_MAX_FRAME, 32'd92);
		send_idle = 76;
		random_frames(80, 10);
		wait_drained();

		write_reg(CFG_MIN_PAYLOAD, 32'd0);
		write_reg(CFG_MAX_PAYLOAD, 32'd0);
		write_reg(CFG_MAX_FRAME, 32'd84);
		send_idle = 0;
		recv_stall = 76;
		random_frames(80, 3);
		repeat (20) @(posedge clk);
		hold_trig = hold_trig + 1;
		wait_drained();

		write_reg(CFG_MIN_PAYLOAD, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_FRAME, 32'd0);
		recv_stall = 32;
		send_idle = 32;
		random_frames(60, 8);
		wait_drained();

		write_reg(CFG_MIN_PAYLOAD, 32'd0);
		write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_FRAME, 32'hFFFF_FFFF);
		random_frames(80, 30);
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end
endmodule
